FILE: hw/rtl/vnn_pkg.sv
// Package for the 2-D vector normalizer with Newton square root.
// Holds widths, register indexes, reset values and the sequencer state type.
// Used by the channel interfaces and the top level.
package vnn_pkg;

	// Payload widths
	localparam int unsigned COMP_W  = 16;   // Q8.8 input components, Q1.14 outputs
	localparam int unsigned SQ_W    = 32;   // squared length, Q16.16
	localparam int unsigned EST_W   = 24;   // root estimate, Q16.8 (integer part up to 16)
	localparam int unsigned PROD_W  = 2 * EST_W;
	localparam int unsigned STEP_W  = 6;
	localparam int unsigned TOL_W   = 16;
	localparam int unsigned DIV_W   = SQ_W; // dividend and quotient width
	localparam int unsigned DCNT_W  = $clog2(DIV_W);
	localparam int unsigned UNIT_SH = 14;   // Q1.14 scaling shift
	localparam int unsigned UMAG_W  = UNIT_SH + 1;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_LIMIT = 2'd0,
		REG_ERR_TOL    = 2'd1
	} vnn_reg_t;

	localparam logic [STEP_W-1:0] STEP_LIMIT_RST = STEP_W'(40);
	localparam logic [TOL_W-1:0]  ERR_TOL_RST    = TOL_W'(66);

	localparam logic [EST_W-1:0]  SEED_FLOOR = EST_W'(256);
	localparam logic [UMAG_W-1:0] UNIT_ONE   = UMAG_W'(16384);
	localparam logic [COMP_W-1:0] LEN_MAX    = '1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_SEED,
		ST_MUL,
		ST_CMP,
		ST_DIV_ROOT,
		ST_UPD,
		ST_DIV_UX,
		ST_DIV_UY,
		ST_FINISH
	} vnn_state_t;

	// Multiplier operand select
	typedef enum logic [1:0] {
		MSEL_X,
		MSEL_Y,
		MSEL_EST
	} vnn_msel_t;

endpackage

FILE: hw/rtl/vnn_if.sv
// Valid/ready channel interfaces of the vector normalizer: input vector,
// result and configuration write. Widths come from vnn_pkg.
interface vnn_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [vnn_pkg::COMP_W-1:0]      vec_x;
	logic signed [vnn_pkg::COMP_W-1:0]      vec_y;

	modport source (output valid, vec_x, vec_y, input ready);
	modport sink   (input valid, vec_x, vec_y, output ready);
endinterface

interface vnn_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [vnn_pkg::COMP_W-1:0]      unit_x;
	logic signed [vnn_pkg::COMP_W-1:0]      unit_y;
	logic        [vnn_pkg::COMP_W-1:0]      length;
	logic                                   zero_vector;

	modport source (output valid, unit_x, unit_y, length, zero_vector, input ready);
	modport sink   (input valid, unit_x, unit_y, length, zero_vector, output ready);
endinterface

interface vnn_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [vnn_pkg::CFG_IDX_W-1:0]          index;
	logic [vnn_pkg::CFG_DATA_W-1:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/vector2_normalize_newton_unit.sv
// Vector normalizer: squared length, Newton-Raphson root, two divides.
// Newton steps taken run from 0 up to the step limit; a zero vector skips the root
// and the divides. One item at a time: an item holds the unit until its result is
// loaded into the output register, its time going mostly to the shared divider.
// Async active-low reset clears the sequencer, output valid and the registers
// (step limit 40, error tolerance 66). Depends on vnn_pkg and vnn_if.
module vector2_normalize_newton_unit (
	input  logic       clk,
	input  logic       arst_n,
	vnn_cfg_if.sink    cfg,
	vnn_in_if.sink     vec_in,
	vnn_out_if.source  res_out
);

	vnn_pkg::vnn_state_t state_q, state_d;

	// Configuration registers
	logic [vnn_pkg::STEP_W-1:0] step_limit_q;
	logic [vnn_pkg::TOL_W-1:0]  err_tol_q;

	// Item registers
	logic [vnn_pkg::COMP_W-1:0]   x_mag_q, y_mag_q;
	logic                         x_neg_q, y_neg_q;
	logic [vnn_pkg::SQ_W-1:0]     s_q;
	logic [vnn_pkg::EST_W-1:0]    est_q;
	logic [vnn_pkg::PROD_W-1:0]   prod_q;
	logic [vnn_pkg::STEP_W-1:0]   steps_q;
	logic                         zero_q;
	logic signed [vnn_pkg::COMP_W-1:0] ux_q, uy_q;

	// Divider registers
	logic [vnn_pkg::DIV_W-1:0]    div_num_q;
	logic [vnn_pkg::EST_W-1:0]    div_rem_q;
	logic [vnn_pkg::DCNT_W-1:0]   div_cnt_q;

	// Output register
	logic                                  out_valid_q;
	logic signed [vnn_pkg::COMP_W-1:0]     out_ux_q, out_uy_q;
	logic        [vnn_pkg::COMP_W-1:0]     out_len_q;
	logic                                  out_zero_q;

	// Control from the sequencer
	logic                   in_ready;
	logic                   out_load;
	vnn_pkg::vnn_msel_t     msel;

	// Datapath signals
	logic [vnn_pkg::EST_W-1:0]    mul_a;
	logic [vnn_pkg::PROD_W-1:0]   mul_p;
	logic [vnn_pkg::SQ_W:0]       limit;
	logic                         need_step;
	logic [vnn_pkg::EST_W:0]      rem_sh;
	logic                         rem_ge;
	logic [vnn_pkg::EST_W-1:0]    rem_nx;
	logic [vnn_pkg::DIV_W-1:0]    num_nx;
	logic                         div_last;
	logic [vnn_pkg::EST_W:0]      upd_sum;
	logic [vnn_pkg::EST_W-1:0]    upd_est;
	logic [vnn_pkg::EST_W-1:0]    seed_raw;
	logic [vnn_pkg::UMAG_W-1:0]   unit_mag;
	logic signed [vnn_pkg::COMP_W-1:0] unit_pos, unit_neg;
	logic [vnn_pkg::DIV_W-1:0]    ux_dividend, uy_dividend;
	logic                         in_acc;

	assign in_acc = vec_in.valid && vec_in.ready;

	// Shared multiplier: squares of the components, then estimate squared
	always_comb begin
		case (msel)
			vnn_pkg::MSEL_X:   mul_a = vnn_pkg::EST_W'(x_mag_q);
			vnn_pkg::MSEL_Y:   mul_a = vnn_pkg::EST_W'(y_mag_q);
			vnn_pkg::MSEL_EST: mul_a = est_q;
			default:           mul_a = est_q;
		endcase
	end
	assign mul_p = mul_a * mul_a;

	// Stop test: estimate squared above target plus tolerance, steps left
	assign limit     = {1'b0, s_q} + (vnn_pkg::SQ_W + 1)'(err_tol_q);
	assign need_step = (prod_q > vnn_pkg::PROD_W'(limit)) && (steps_q < step_limit_q);

	// Restoring divider step, one quotient bit per cycle; divisor is the estimate
	assign rem_sh   = {div_rem_q, div_num_q[vnn_pkg::DIV_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, est_q};
	assign rem_nx   = rem_ge ? vnn_pkg::EST_W'(rem_sh - {1'b0, est_q})
	                         : rem_sh[vnn_pkg::EST_W-1:0];
	assign num_nx   = {div_num_q[vnn_pkg::DIV_W-2:0], rem_ge};
	assign div_last = div_cnt_q == vnn_pkg::DCNT_W'(vnn_pkg::DIV_W - 1);

	// Newton update; quotient is below the estimate here, so it fits EST_W
	assign upd_sum = {1'b0, est_q} + {1'b0, num_nx[vnn_pkg::EST_W-1:0]};
	assign upd_est = (upd_sum[vnn_pkg::EST_W:1] == '0) ? vnn_pkg::EST_W'(1)
	                                                   : upd_sum[vnn_pkg::EST_W:1];

	// Seed is max(S >> 8, 1.0)
	assign seed_raw = s_q[vnn_pkg::SQ_W-1:8];

	// Unit component: clamp quotient to 1.0, then apply sign
	assign unit_mag = (num_nx > vnn_pkg::DIV_W'(vnn_pkg::UNIT_ONE)) ? vnn_pkg::UNIT_ONE
	                : num_nx[vnn_pkg::UMAG_W-1:0];
	assign unit_pos = vnn_pkg::COMP_W'(unit_mag);
	assign unit_neg = -unit_pos;

	assign ux_dividend = vnn_pkg::DIV_W'(x_mag_q) << vnn_pkg::UNIT_SH;
	assign uy_dividend = vnn_pkg::DIV_W'(y_mag_q) << vnn_pkg::UNIT_SH;

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vnn_pkg::ST_IDLE:     if (in_acc) state_d = vnn_pkg::ST_SQX;
			vnn_pkg::ST_SQX:      state_d = vnn_pkg::ST_SQY;
			vnn_pkg::ST_SQY:      state_d = vnn_pkg::ST_SUM;
			vnn_pkg::ST_SUM:      state_d = vnn_pkg::ST_SEED;
			vnn_pkg::ST_SEED:     state_d = zero_q ? vnn_pkg::ST_FINISH : vnn_pkg::ST_MUL;
			vnn_pkg::ST_MUL:      state_d = vnn_pkg::ST_CMP;
			vnn_pkg::ST_CMP:      state_d = need_step ? vnn_pkg::ST_DIV_ROOT
			                                          : vnn_pkg::ST_DIV_UX;
			vnn_pkg::ST_DIV_ROOT: if (div_last) state_d = vnn_pkg::ST_UPD;
			vnn_pkg::ST_UPD:      state_d = vnn_pkg::ST_MUL;
			vnn_pkg::ST_DIV_UX:   if (div_last) state_d = vnn_pkg::ST_DIV_UY;
			vnn_pkg::ST_DIV_UY:   if (div_last) state_d = vnn_pkg::ST_FINISH;
			vnn_pkg::ST_FINISH:   if (out_load) state_d = vnn_pkg::ST_IDLE;
			default:              state_d = vnn_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		msel     = vnn_pkg::MSEL_EST;
		case (state_q)
			vnn_pkg::ST_IDLE:   in_ready = 1'b1;
			vnn_pkg::ST_SQX:    msel = vnn_pkg::MSEL_X;
			vnn_pkg::ST_SQY:    msel = vnn_pkg::MSEL_Y;
			vnn_pkg::ST_FINISH: out_load = !out_valid_q || res_out.ready;
			default:            msel = vnn_pkg::MSEL_EST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vnn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_limit_q <= vnn_pkg::STEP_LIMIT_RST;
			err_tol_q    <= vnn_pkg::ERR_TOL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				vnn_pkg::REG_STEP_LIMIT: step_limit_q <= cfg.data[vnn_pkg::STEP_W-1:0];
				vnn_pkg::REG_ERR_TOL:    err_tol_q    <= cfg.data[vnn_pkg::TOL_W-1:0];
				default:                 ;
			endcase
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			vnn_pkg::ST_IDLE: begin
				if (in_acc) begin
					x_neg_q <= vec_in.vec_x[vnn_pkg::COMP_W-1];
					y_neg_q <= vec_in.vec_y[vnn_pkg::COMP_W-1];
					x_mag_q <= vec_in.vec_x[vnn_pkg::COMP_W-1] ? 16'(-vec_in.vec_x)
					                                           : 16'(vec_in.vec_x);
					y_mag_q <= vec_in.vec_y[vnn_pkg::COMP_W-1] ? 16'(-vec_in.vec_y)
					                                           : 16'(vec_in.vec_y);
				end
			end
			vnn_pkg::ST_SQX: prod_q <= mul_p;
			vnn_pkg::ST_SQY: begin
				s_q    <= prod_q[vnn_pkg::SQ_W-1:0];
				prod_q <= mul_p;
			end
			vnn_pkg::ST_SUM: begin
				s_q    <= s_q + prod_q[vnn_pkg::SQ_W-1:0];
				zero_q <= (s_q == '0) && (prod_q == '0);
			end
			vnn_pkg::ST_SEED: begin
				est_q   <= (seed_raw < vnn_pkg::SEED_FLOOR) ? vnn_pkg::SEED_FLOOR : seed_raw;
				steps_q <= '0;
				ux_q    <= '0;
				uy_q    <= '0;
			end
			vnn_pkg::ST_MUL: prod_q <= mul_p;
			vnn_pkg::ST_CMP: begin
				div_rem_q <= '0;
				div_cnt_q <= '0;
				div_num_q <= need_step ? s_q : ux_dividend;
			end
			vnn_pkg::ST_DIV_ROOT: begin
				div_rem_q <= rem_nx;
				div_num_q <= num_nx;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_last) begin
					est_q   <= upd_est;
					steps_q <= steps_q + 1'b1;
				end
			end
			vnn_pkg::ST_DIV_UX: begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_last) begin
					ux_q      <= x_neg_q ? unit_neg : unit_pos;
					div_rem_q <= '0;
					div_num_q <= uy_dividend;
				end else begin
					div_rem_q <= rem_nx;
					div_num_q <= num_nx;
				end
			end
			vnn_pkg::ST_DIV_UY: begin
				div_rem_q <= rem_nx;
				div_num_q <= num_nx;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_last) begin
					uy_q <= y_neg_q ? unit_neg : unit_pos;
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a result while the next item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_zero_q <= zero_q;
			out_ux_q   <= ux_q;
			out_uy_q   <= uy_q;
			if (zero_q) begin
				out_len_q <= '0;
			end else if (est_q > vnn_pkg::EST_W'(vnn_pkg::LEN_MAX)) begin
				out_len_q <= vnn_pkg::LEN_MAX;
			end else begin
				out_len_q <= est_q[vnn_pkg::COMP_W-1:0];
			end
		end
	end

	assign cfg.ready           = 1'b1;
	assign vec_in.ready        = in_ready;
	assign res_out.valid       = out_valid_q;
	assign res_out.unit_x      = out_ux_q;
	assign res_out.unit_y      = out_uy_q;
	assign res_out.length      = out_len_q;
	assign res_out.zero_vector = out_zero_q;

endmodule

FILE: tb/vector2_normalize_newton_unit_test.sv
// Testbench for vector2_normalize_newton_unit: directed and random vectors against an
// in-bench normalizer, with random stalls on both sides and register changes.
// Depends on vnn_pkg, the vnn_if channel interfaces and the unit itself.
`timescale 1ns / 100ps

module vector2_normalize_newton_unit_test;

	localparam longint unsigned CYCLE_LIMIT   = 15_000_000;
	localparam int              RAND_PHASES   = 9;
	localparam int              PHASE_ITEMS   = 150;
	localparam int              HOLD_AT_COUNT = 200;
	localparam int              HOLD_CYCLES   = 3000;
	localparam int              TAIL_CYCLES   = 80;

	typedef struct {
		logic signed [vnn_pkg::COMP_W-1:0] unit_x;
		logic signed [vnn_pkg::COMP_W-1:0] unit_y;
		logic        [vnn_pkg::COMP_W-1:0] length;
		logic                              zero_vector;
	} norm_result_t;

	// Expected normalizer results, oldest first, with a private copy of the registers
	class norm_scoreboard;
		logic [vnn_pkg::STEP_W-1:0] step_limit;
		logic [vnn_pkg::TOL_W-1:0]  tolerance;
		norm_result_t               expected_norms[$];
		int                         errors;

		function new();
			step_limit = vnn_pkg::STEP_LIMIT_RST;
			tolerance  = vnn_pkg::ERR_TOL_RST;
			errors     = 0;
		endfunction

		function void set_config(logic [vnn_pkg::STEP_W-1:0] steps,
				logic [vnn_pkg::TOL_W-1:0] tol);
			step_limit = steps;
			tolerance  = tol;
		endfunction

		function int pending();
			return expected_norms.size();
		endfunction

		// Truncating integer Newton root in Q8.8, seeded at max(S/256, 1.0)
		function longint unsigned newton_root(longint unsigned sq);
			longint unsigned est;
			longint unsigned lim;
			int              n;
			est = sq >> 8;
			if (est < vnn_pkg::SEED_FLOOR)
				est = vnn_pkg::SEED_FLOOR;
			lim = sq + tolerance;
			n   = 0;
			while (est * est > lim && n < step_limit) begin
				est = (est + sq / est) >> 1;
				if (est == 0)
					est = 1;
				n++;
			end
			return est;
		endfunction

		// component * 2^14 / len, toward zero, clamped to unit magnitude
		function logic [vnn_pkg::COMP_W-1:0] unit_of(longint comp, longint unsigned len);
			longint unsigned mag;
			longint unsigned q;
			mag = (comp < 0) ? -comp : comp;
			q   = (mag << vnn_pkg::UNIT_SH) / len;
			if (q > vnn_pkg::UNIT_ONE)
				q = vnn_pkg::UNIT_ONE;
			return (comp < 0) ? vnn_pkg::COMP_W'(-q) : vnn_pkg::COMP_W'(q);
		endfunction

		function norm_result_t normalize_vec(logic signed [vnn_pkg::COMP_W-1:0] x,
				logic signed [vnn_pkg::COMP_W-1:0] y);
			norm_result_t    r;
			longint          sx;
			longint          sy;
			longint unsigned sq;
			longint unsigned len;
			sx = x;
			sy = y;
			sq = sx * sx + sy * sy;
			r.unit_x      = '0;
			r.unit_y      = '0;
			r.length      = '0;
			r.zero_vector = 1'b1;
			if (sq != 0) begin
				len           = newton_root(sq);
				r.unit_x      = unit_of(sx, len);
				r.unit_y      = unit_of(sy, len);
				r.length      = (len > vnn_pkg::LEN_MAX) ? vnn_pkg::LEN_MAX
				                                         : vnn_pkg::COMP_W'(len);
				r.zero_vector = 1'b0;
			end
			return r;
		endfunction

		function void note_vector(logic signed [vnn_pkg::COMP_W-1:0] x,
				logic signed [vnn_pkg::COMP_W-1:0] y);
			expected_norms.push_back(normalize_vec(x, y));
		endfunction

		function void field_ok(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_norm(norm_result_t got);
			norm_result_t want;
			if (expected_norms.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual x=%0d y=%0d len=%0d z=%0b",
					$time, got.unit_x, got.unit_y, got.length, got.zero_vector);
				return;
			end
			want = expected_norms.pop_front();
			field_ok("unit_x", want.unit_x, got.unit_x);
			field_ok("unit_y", want.unit_y, got.unit_y);
			field_ok("length", want.length, got.length);
			field_ok("zero_vector", want.zero_vector, got.zero_vector);
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	longint unsigned cycles;
	bit              no_idle;
	int              results_seen;
	norm_scoreboard  sb;

	vnn_cfg_if cfg_if ();
	vnn_in_if  vec_if ();
	vnn_out_if res_if ();

	vector2_normalize_newton_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.vec_in  (vec_if),
		.res_out (res_if)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Component mix: full range, small, zero, extremes, powers of two, mid-size
	function automatic logic signed [vnn_pkg::COMP_W-1:0] rand_comp();
		logic signed [vnn_pkg::COMP_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = vnn_pkg::COMP_W'($urandom);
			4, 5:       v = vnn_pkg::COMP_W'($urandom_range(0, 600) - 300);
			6:          v = '0;
			7: begin
				case ($urandom_range(0, 4))
					0:       v = 16'sh8000;
					1:       v = 16'sh7FFF;
					2:       v = 16'sh8001;
					3:       v = 16'sd1;
					default: v = -16'sd1;
				endcase
			end
			8: begin
				v = 16'sd1 <<< $urandom_range(0, 14);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default:    v = vnn_pkg::COMP_W'($urandom_range(0, 8000) - 4000);
		endcase
		return v;
	endfunction

	// Offer one vector, hold it until accepted, then maybe idle
	task automatic send_vec(input logic signed [vnn_pkg::COMP_W-1:0] x,
			input logic signed [vnn_pkg::COMP_W-1:0] y);
		int gap;
		vec_if.valid <= 1'b1;
		vec_if.vec_x <= x;
		vec_if.vec_y <= y;
		@(posedge clk);
		while (!vec_if.ready)
			@(posedge clk);
		sb.note_vector(x, y);
		gap = pick_gap();
		if (gap > 0) begin
			vec_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Both registers back to back; upper data bits of the step limit are don't-care
	task automatic write_config(input logic [vnn_pkg::STEP_W-1:0] steps,
			input logic [vnn_pkg::TOL_W-1:0] tol);
		logic [vnn_pkg::CFG_DATA_W-vnn_pkg::STEP_W-1:0] junk;
		junk = (vnn_pkg::CFG_DATA_W - vnn_pkg::STEP_W)'($urandom);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= vnn_pkg::REG_STEP_LIMIT;
		cfg_if.data  <= {junk, steps};
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.index <= vnn_pkg::REG_ERR_TOL;
		cfg_if.data  <= tol;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		sb.set_config(steps, tol);
	endtask

	// Stop offering and let every expected result come back
	task automatic drain();
		vec_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Result side: check accepted items, random stalls, one long hold-off
	initial begin
		int  stall_left;
		bit  held;
		norm_result_t got;
		stall_left   = 0;
		held         = 1'b0;
		results_seen = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.unit_x      = res_if.unit_x;
				got.unit_y      = res_if.unit_y;
				got.length      = res_if.length;
				got.zero_vector = res_if.zero_vector;
				sb.check_norm(got);
				results_seen++;
			end
			if (!held && results_seen == HOLD_AT_COUNT) begin
				held       = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				res_if.ready <= 1'b1;
				if ($urandom_range(0, 99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// Stimulus
	initial begin
		logic [vnn_pkg::STEP_W-1:0] steps;
		logic [vnn_pkg::TOL_W-1:0]  tol;
		sb           = new();
		no_idle      = 1'b0;
		arst_n       = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = vnn_pkg::REG_STEP_LIMIT;
		cfg_if.data  = '0;
		vec_if.valid = 1'b0;
		vec_if.vec_x = '0;
		vec_if.vec_y = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register values: zero vector, extremes, exact roots, one-LSB vectors
		send_vec(16'sd0, 16'sd0);
		send_vec(16'sh8000, 16'sh8000);
		send_vec(16'sh7FFF, 16'sh7FFF);
		send_vec(16'sh8000, 16'sd0);
		send_vec(16'sd0, 16'sh8000);
		send_vec(16'sh7FFF, 16'sh8000);
		send_vec(16'sd1, 16'sd0);
		send_vec(16'sd0, -16'sd1);
		send_vec(16'sd1, 16'sd1);
		send_vec(-16'sd3, 16'sd4);
		send_vec(16'sd256, -16'sd256);
		send_vec(16'sd100, -16'sd200);
		send_vec(16'sd1, 16'sh7FFF);
		drain();

		// No Newton steps: the seed is the length, saturating when large
		write_config('0, '0);
		send_vec(16'sd1, 16'sd0);
		send_vec(16'sh8000, 16'sh8000);
		send_vec(16'sd256, 16'sd256);
		send_vec(16'sd0, 16'sd0);
		send_vec(16'sd16, -16'sd16);
		drain();

		// One step with a loose tolerance: early stop leaves a too-large estimate
		write_config(6'd1, '1);
		send_vec(16'sh7FFF, 16'sh7FFF);
		send_vec(-16'sd20000, 16'sd5000);
		send_vec(16'sd5, 16'sd5);
		send_vec(-16'sd2, -16'sd700);
		drain();

		// Random phases, register extremes first
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0) begin
				steps = '1;
				tol   = '1;
			end else if (p == 1) begin
				steps = 6'd1;
				tol   = '0;
			end else begin
				case ($urandom_range(0, 5))
					0:       steps = '0;
					1:       steps = 6'd1;
					2:       steps = '1;
					default: steps = vnn_pkg::STEP_W'($urandom_range(0, 63));
				endcase
				case ($urandom_range(0, 3))
					0:       tol = '0;
					1:       tol = '1;
					default: tol = vnn_pkg::TOL_W'($urandom);
				endcase
			end
			write_config(steps, tol);
			no_idle = (p % 3 == 2);
			repeat (PHASE_ITEMS) send_vec(rand_comp(), rand_comp());
			drain();
			no_idle = 1'b0;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: vector2_normalize_newton_unit.f
hw/rtl/vnn_pkg.sv
hw/rtl/vnn_if.sv
hw/rtl/vector2_normalize_newton_unit.sv
tb/vector2_normalize_newton_unit_test.sv
